// ===== hdl/gf2qse_pkg.sv =====
`timescale 1ns / 1ps

package gf2qse_pkg;

  // Fixed field widths of the stream items.
  localparam int ADDR_FIELD_W = 8;
  localparam int WORD_W       = 32;
  localparam int ASSIGN_W     = 16;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_TDATA_W  = 32;

  // Command to every cell of the variable chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_STEP,
    OP_LIN_END,
    OP_ROW_END
  } cell_op_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic col;       // column token: selects the second variable of a term
    logic row;       // row token: selects the first variable of a pair
    logic row_prev;  // row token of the cell before this one
  } cell_link_t;

endpackage

// ===== hdl/gf2_quadratic_system_eval_unit.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid / s_axis_tready tuser: func; tdata: addr, word, assignment
// m_axis    out        m_axis_tvalid / m_axis_tready tdata: equation_values
//
// A write item stores its word in the coefficient RAM; writes past the end of
// the store are dropped. An evaluate item walks the whole coefficient RAM of
// DEPTH = 1 + NUM_VARS + NUM_VARS * (NUM_VARS - 1) / 2 words through its
// single read port, one word per cycle, and the block takes no new item
// until the walk is done. The result waits in the output register, and
// further items are taken while it waits. Reset is synchronous and active
// high; the coefficient RAM is not cleared and must be written before evaluation.
`timescale 1ns / 1ps

module gf2_quadratic_system_eval_unit #(
  parameter int NUM_VARS      = 16,
  parameter int NUM_EQUATIONS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] coeff_addr, [39:8] coeff_word, [55:40] assignment
  input  logic [gf2qse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] equation_values
  output logic [gf2qse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Store layout: constant word, NUM_VARS linear words, then the pairs.
  localparam int DEPTH = 1 + NUM_VARS + (NUM_VARS * (NUM_VARS - 1)) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (AW > gf2qse_pkg::ADDR_FIELD_W) ? AW : gf2qse_pkg::ADDR_FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONST,
    S_LIN,
    S_QUAD,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state;

  // Unpacked input item.
  logic                                  func;
  logic [gf2qse_pkg::ADDR_FIELD_W-1:0]   coeff_addr;
  logic [gf2qse_pkg::WORD_W-1:0]         coeff_word;
  logic [gf2qse_pkg::ASSIGN_W-1:0]       assignment;

  assign func       = s_axis_tuser;
  assign coeff_addr = s_axis_tdata[7:0];
  assign coeff_word = s_axis_tdata[39:8];
  assign assignment = s_axis_tdata[55:40];

  logic in_acc;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Write port: addresses past the end of the store are dropped.
  logic [CMP_W-1:0] addr_ext;
  logic             addr_ok;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  assign addr_ext = CMP_W'(coeff_addr);
  assign addr_ok  = addr_ext < CMP_W'(DEPTH);
  assign wr_en    = in_acc & ~func & addr_ok;
  assign wr_addr  = AW'(addr_ext);

  // Read sequencer: pos walks the store in the order the terms are laid out.
  logic [AW-1:0]            pos;
  logic                     rd_en;
  logic [NUM_EQUATIONS-1:0] rd_data;
  logic                     vld_pipe;
  logic                     en_pipe;
  logic [NUM_EQUATIONS-1:0] acc;

  assign rd_en = (state == S_CONST) || (state == S_LIN) || (state == S_QUAD);

  gf2qse_ram #(
    .WIDTH (NUM_EQUATIONS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (NUM_EQUATIONS'(coeff_word)),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  // Variable chain. Cell j holds variable j; the column token sweeps the
  // linear terms and then the second variable of each pair, while the row
  // token marks the first variable of the current pair row.
  gf2qse_pkg::cell_op_t   cell_op;
  gf2qse_pkg::cell_link_t link_out [NUM_VARS];
  logic [NUM_VARS-1:0]    hit_col;
  logic [NUM_VARS-1:0]    hit_row;
  logic [NUM_VARS-1:0]    col_vec;
  logic [NUM_VARS-1:0]    row_vec;

  for (genvar j = 0; j < NUM_VARS; j++) begin : g_cell
    logic                   x_load;
    gf2qse_pkg::cell_link_t link_in;

    if (j < gf2qse_pkg::ASSIGN_W) begin : g_var
      assign x_load = assignment[j];
    end else begin : g_zero
      // Variables beyond the assignment field read as zero.
      assign x_load = 1'b0;
    end

    if (j == 0) begin : g_head
      assign link_in = '0;
    end else begin : g_body
      assign link_in = link_out[j-1];
    end

    gf2qse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (cell_op),
      .seed     (j == 0),
      .x_load   (x_load),
      .link_in  (link_in),
      .link_out (link_out[j]),
      .hit_col  (hit_col[j]),
      .hit_row  (hit_row[j])
    );

    assign col_vec[j] = link_out[j].col;
    assign row_vec[j] = link_out[j].row;
  end

  logic col_last;
  logic row_last;
  logic sel_x;
  logic row_x;
  logic en_now;

  assign col_last = link_out[NUM_VARS-1].col;
  assign row_last = link_out[NUM_VARS-2].row;
  assign sel_x    = |hit_col;
  assign row_x    = |hit_row;

  always_comb begin
    cell_op = gf2qse_pkg::OP_HOLD;
    en_now  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && func) begin
          cell_op = gf2qse_pkg::OP_LOAD;
        end
      end
      S_CONST: begin
        en_now = 1'b1;
      end
      S_LIN: begin
        en_now  = sel_x;
        cell_op = col_last ? gf2qse_pkg::OP_LIN_END : gf2qse_pkg::OP_STEP;
      end
      S_QUAD: begin
        en_now  = sel_x & row_x;
        cell_op = col_last ? gf2qse_pkg::OP_ROW_END : gf2qse_pkg::OP_STEP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      vld_pipe      <= 1'b0;
    end else begin
      vld_pipe <= rd_en;
      en_pipe  <= en_now;

      // Fold in the word read last cycle when its term is active.
      if (vld_pipe && en_pipe) begin
        acc <= acc ^ rd_data;
      end

      // The finishing step handles its own handover of the output register.
      if (m_axis_tvalid && m_axis_tready && (state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && func) begin
            acc   <= '0;
            pos   <= '0;
            state <= S_CONST;
          end
        end
        S_CONST: begin
          pos   <= pos + AW'(1);
          state <= S_LIN;
        end
        S_LIN: begin
          pos <= pos + AW'(1);
          if (col_last) begin
            state <= S_QUAD;
          end
        end
        S_QUAD: begin
          pos <= pos + AW'(1);
          if (col_last && row_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= gf2qse_pkg::OUT_TDATA_W'(acc);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The sweep must end exactly on the last store entry.
  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> ($past(pos) == AW'(DEPTH - 1)))
    else $error("pair sweep ended away from the last store entry");

  // Exactly one row token and one column token while terms are issued.
  a_tokens: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIN || state == S_QUAD) |-> ($onehot(col_vec) && $onehot(row_vec)))
    else $error("variable chain lost or duplicated a token");

  // A result is only presented by the final step of an evaluation.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FIN))
    else $error("result appeared outside the finishing step");

endmodule

// ===== hdl/gf2qse_ram.sv =====
`timescale 1ns / 1ps

module gf2qse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 137,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/gf2qse_cell.sv =====
`timescale 1ns / 1ps

// One variable of the assignment. The row and column tokens walk the chain
// so that the cells holding them name the two variables of the current term.
module gf2qse_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  gf2qse_pkg::cell_op_t   op,
  input  logic                   seed,
  input  logic                   x_load,
  input  gf2qse_pkg::cell_link_t link_in,
  output gf2qse_pkg::cell_link_t link_out,
  output logic                   hit_col,
  output logic                   hit_row
);

  logic x;
  logic col;
  logic row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 1'b0;
      row <= 1'b0;
    end else begin
      unique case (op)
        gf2qse_pkg::OP_HOLD: begin
        end
        gf2qse_pkg::OP_LOAD: begin
          col <= seed;
          row <= seed;
        end
        gf2qse_pkg::OP_STEP: begin
          col <= link_in.col;
        end
        gf2qse_pkg::OP_LIN_END: begin
          col <= link_in.row;
        end
        gf2qse_pkg::OP_ROW_END: begin
          col <= link_in.row_prev;
          row <= link_in.row;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == gf2qse_pkg::OP_LOAD) begin
      x <= x_load;
    end
  end

  assign link_out.col      = col;
  assign link_out.row      = row;
  assign link_out.row_prev = link_in.row;
  assign hit_col           = col & x;
  assign hit_row           = row & x;

endmodule

// ===== verif/gf2_quadratic_system_eval_unit_tb.sv =====
`timescale 1ns / 1ps

module gf2_quadratic_system_eval_unit_tb;

  localparam int NUM_VARS      = 16;
  localparam int NUM_EQUATIONS = 32;
  // Constant word, one linear word per variable, one word per pair i<j.
  localparam int STORE_DEPTH   = 1 + NUM_VARS + (NUM_VARS * (NUM_VARS - 1)) / 2;
  localparam int QUAD_BASE     = 1 + NUM_VARS;

  // Values carried in tuser.
  localparam bit FN_WRITE = 1'b0;
  localparam bit FN_EVAL  = 1'b1;

  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_HOLD    = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic                                clk;
  logic                                rst;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  // [7:0] coeff_addr, [39:8] coeff_word, [55:40] assignment
  logic [gf2qse_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
  // [0] func
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // [31:0] equation_values
  logic [gf2qse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  gf2_quadratic_system_eval_unit #(
    .NUM_VARS      (NUM_VARS),
    .NUM_EQUATIONS (NUM_EQUATIONS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the coefficient store and the queue of equation values
  // still owed by the block, oldest first.
  logic [NUM_EQUATIONS-1:0]            coeff_shadow [STORE_DEPTH];
  logic [gf2qse_pkg::OUT_TDATA_W-1:0]  owed_values [$];

  int  err_count  = 0;
  int  n_writes   = 0;
  int  n_dropped  = 0;
  int  n_evals    = 0;
  int  n_checked  = 0;
  int  burst_left = 0;
  bit  rx_hold_req = 1'b0;

  typedef struct {
    bit                                 func;
    logic [7:0]                         addr;
    logic [gf2qse_pkg::WORD_W-1:0]      word;
    logic [gf2qse_pkg::ASSIGN_W-1:0]    assignment;
    bit                                 fixed;      // expected value typed into the row
    logic [gf2qse_pkg::OUT_TDATA_W-1:0] fixed_val;
  } stim_row_t;

  stim_row_t dir_rows [20];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sums the constant word, the linear words of the variables that are set
  // and the quadratic words of the pairs that are both set, all in GF(2).
  function automatic logic [gf2qse_pkg::OUT_TDATA_W-1:0] eval_system(
    input logic [gf2qse_pkg::ASSIGN_W-1:0] asg);
    logic [NUM_EQUATIONS-1:0] acc;
    int pos;
    acc = coeff_shadow[0];
    pos = QUAD_BASE;
    for (int a = 0; a < NUM_VARS; a++) begin
      if (asg[a]) acc ^= coeff_shadow[1 + a];
    end
    for (int a = 0; a < NUM_VARS; a++) begin
      for (int b = a + 1; b < NUM_VARS; b++) begin
        if (asg[a] && asg[b]) acc ^= coeff_shadow[pos];
        pos++;
      end
    end
    return gf2qse_pkg::OUT_TDATA_W'(acc);
  endfunction

  // Offers one item in the sender's burst pattern and waits for the
  // handshake. On acceptance the shadow store is updated, or for an
  // evaluation the expected equation values are queued.
  task automatic send_item(input bit func, input logic [7:0] addr,
                           input logic [gf2qse_pkg::WORD_W-1:0] word,
                           input logic [gf2qse_pkg::ASSIGN_W-1:0] asg,
                           input bit fixed,
                           input logic [gf2qse_pkg::OUT_TDATA_W-1:0] fixed_val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {asg, word, addr};
    do @(posedge clk); while (!s_axis_tready);
    if (func == FN_WRITE) begin
      n_writes++;
      if (addr < STORE_DEPTH) coeff_shadow[addr] = word[NUM_EQUATIONS-1:0];
      else n_dropped++;
    end else begin
      n_evals++;
      owed_values.push_back(fixed ? fixed_val : eval_system(asg));
    end
  endtask

  // Receiver: phases of random length, each with its own stall rate, plus
  // one long hold-off on request so that the block backs up.
  initial begin
    int phase_left;
    int stall_pct;
    int hold_left;
    phase_left = 0;
    stall_pct  = 0;
    hold_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 400);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 75;
          endcase
        end
        phase_left--;
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every accepted result is checked against the oldest owed value.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_values.size() == 0) begin
        $error("equation_values: no result expected, got %h", m_axis_tdata);
        err_count++;
      end else begin
        if (m_axis_tdata !== owed_values[0]) begin
          $error("equation_values: expected %h, got %h", owed_values[0], m_axis_tdata);
          err_count++;
        end
        void'(owed_values.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    logic [gf2qse_pkg::ASSIGN_W-1:0] asg;
    logic [7:0]                      addr;
    int                              kind;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FN_WRITE;
    s_axis_tdata  = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The block's store is undefined after reset, so every entry gets a
    // known value before the first evaluation. Zero keeps the directed
    // expectations easy to read.
    for (int k = 0; k < STORE_DEPTH; k++) begin
      send_item(FN_WRITE, 8'(k), '0, gf2qse_pkg::ASSIGN_W'($urandom), 1'b0, '0);
    end

    // Directed rows: empty system, full constant, out-of-range writes,
    // single linear and quadratic terms at both ends of the store.
    // Ignored fields carry their extremes on some rows.
    dir_rows = '{
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000},
      '{FN_EVAL,  8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0000_0000},
      '{FN_WRITE, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0},
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 32'hFFFF_FFFF},
      '{FN_WRITE, 8'hFF, 32'h1234_5678, 16'h0000, 1'b0, 32'h0},
      '{FN_WRITE, 8'd137, 32'hA5A5_A5A5, 16'h5A5A, 1'b0, 32'h0},
      '{FN_EVAL,  8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF},
      '{FN_WRITE, 8'd1,  32'h0000_FFFF, 16'h0000, 1'b0, 32'h0},
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'h0001, 1'b1, 32'hFFFF_0000},
      '{FN_WRITE, 8'd16, 32'hFFFF_0000, 16'h0000, 1'b0, 32'h0},
      '{FN_WRITE, 8'd17, 32'hF0F0_F0F0, 16'h0000, 1'b0, 32'h0},
      '{FN_WRITE, 8'd136, 32'h8000_0001, 16'h0000, 1'b0, 32'h0},
      '{FN_EVAL,  8'h11, 32'h0F0F_0F0F, 16'h0003, 1'b0, 32'h0},
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'hC000, 1'b0, 32'h0},
      '{FN_EVAL,  8'h88, 32'h8000_0000, 16'h8000, 1'b0, 32'h0},
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'hFFFF, 1'b0, 32'h0},
      '{FN_WRITE, 8'd0,  32'h0000_0000, 16'hFFFF, 1'b0, 32'h0},
      '{FN_EVAL,  8'h00, 32'h0000_0000, 16'h0002, 1'b0, 32'h0},
      '{FN_WRITE, 8'd136, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
      '{FN_EVAL,  8'h7F, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h0}
    };
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].func, dir_rows[r].addr, dir_rows[r].word,
                dir_rows[r].assignment, dir_rows[r].fixed, dir_rows[r].fixed_val);
    end

    // Random mix of writes and evaluations. Sparse assignments isolate
    // single terms; dense ones sum most of the store.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) rx_hold_req = 1'b1;
      if (i == 700) begin
        // Let the block run dry before going on.
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (owed_values.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      case ($urandom_range(0, 7))
        0:       asg = 16'hFFFF;
        1, 2:    asg = gf2qse_pkg::ASSIGN_W'(1) << $urandom_range(0, NUM_VARS - 1);
        3:       asg = (gf2qse_pkg::ASSIGN_W'(1) << $urandom_range(0, NUM_VARS - 1))
                       | (gf2qse_pkg::ASSIGN_W'(1) << $urandom_range(0, NUM_VARS - 1));
        default: asg = gf2qse_pkg::ASSIGN_W'($urandom);
      endcase
      kind = $urandom_range(0, 19);
      if (kind < 2) addr = 8'($urandom_range(STORE_DEPTH, 255));
      else if (kind < 4) addr = 8'(($urandom_range(0, 1) == 1) ? STORE_DEPTH - 1 : 0);
      else addr = 8'($urandom_range(0, STORE_DEPTH - 1));
      send_item((kind >= 11) ? FN_EVAL : FN_WRITE, addr,
                gf2qse_pkg::WORD_W'($urandom), asg, 1'b0, '0);
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (owed_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d coefficient writes (%0d to addresses past the store) and %0d evaluations;",
             n_writes, n_dropped, n_evals);
    $display("%0d equation-value results were compared under random backpressure.", n_checked);
    if (err_count == 0) begin
      $display("gf2_quadratic_system_eval_unit: match");
    end else begin
      $display("gf2_quadratic_system_eval_unit: mismatch");
    end
    $finish;
  end

  // A correct run ends before this timeout even if every item were an
  // evaluation held up by the slowest receiver phases.
  initial begin
    #10ms;
    $display("gf2_quadratic_system_eval_unit: mismatch");
    $finish;
  end

endmodule
